[src/msnsig_pkg.sv]
package msnsig_pkg;

  localparam int REG_W = 16;
  localparam int K_W   = 10;
  localparam int IDX_W = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_SIGMA_ALPHA = 3'd0,
    REG_SIGMA_MS    = 3'd1,
    REG_K1_SCALE    = 3'd2,
    REG_SIGMA_TOF   = 3'd3,
    REG_SIGMA_EMC   = 3'd4
  } reg_idx_t;

  localparam logic [REG_W-1:0] RST_SIGMA_ALPHA = 16'd750;
  localparam logic [REG_W-1:0] RST_SIGMA_MS    = 16'd570;
  localparam logic [K_W-1:0]   RST_K1_SCALE    = 10'd84;
  localparam logic [REG_W-1:0] RST_SIGMA_TOF   = 16'd140;
  localparam logic [REG_W-1:0] RST_SIGMA_EMC   = 16'd340;

  typedef struct packed {
    logic               mode;
    logic [9:0]         track_tag;
    logic signed [15:0] measured_mass_sq;
    logic [17:0]        flight_time_ps;
    logic [14:0]        momentum;
    logic [14:0]        hypothesis_mass_sq;
  } trk_t;

  typedef struct packed {
    logic [9:0]         track_tag_out;
    logic signed [15:0] n_sigma;
    logic               result_valid;
  } res_t;

  // Long-division cell: remainder, divisor and a numerator register that
  // takes in quotient bits at its low end as the numerator leaves its top.
  localparam int DIV_NW = 96;
  localparam int DIV_RW = 34;

  typedef struct packed {
    logic [DIV_RW-1:0] rem;
    logic [DIV_RW-1:0] den;
    logic [DIV_NW-1:0] num;
  } div_t;

  // Square-root cell: two radicand bits and one root bit per cell.
  localparam int SQ_VW = 64;
  localparam int SQ_RW = 34;
  localparam int SQ_QW = 32;

  typedef struct packed {
    logic [SQ_RW-1:0] rem;
    logic [SQ_QW-1:0] root;
    logic [SQ_VW-1:0] val;
  } sq_t;

  localparam int STEPS_A  = 48;
  localparam int STEPS_B  = 94;
  localparam int STEPS_SQ = SQ_QW;
  localparam int STEPS_Q  = 34;

  localparam int LAT = 2 + STEPS_A + 3 + STEPS_B + 3 + STEPS_SQ + 1 + STEPS_Q + 1;

  localparam logic [62:0] SAT_CAP = {1'b1, 62'd0};

endpackage

[src/msnsig_div_cell.sv]
module msnsig_div_cell (
  input  logic              clk,
  input  logic              en,
  input  msnsig_pkg::div_t  cur,
  output msnsig_pkg::div_t  nxt
);
  import msnsig_pkg::*;

  logic [DIV_RW-1:0] trial;
  logic              ge;
  div_t              step;

  always_comb begin
    trial     = {cur.rem[DIV_RW-2:0], cur.num[DIV_NW-1]};
    ge        = (trial >= cur.den);
    step.den  = cur.den;
    step.rem  = ge ? (trial - cur.den) : trial;
    step.num  = {cur.num[DIV_NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nxt <= step;
    end
  end

endmodule

[src/msnsig_sqrt_cell.sv]
module msnsig_sqrt_cell (
  input  logic             clk,
  input  logic             en,
  input  msnsig_pkg::sq_t  cur,
  output msnsig_pkg::sq_t  nxt
);
  import msnsig_pkg::*;

  logic [SQ_RW+1:0] trem;
  logic [SQ_RW+1:0] trial;
  logic             ge;
  sq_t              step;

  always_comb begin
    trem      = {cur.rem, cur.val[SQ_VW-1 -: 2]};
    trial     = (SQ_RW+2)'({cur.root, 2'b01});
    ge        = (trem >= trial);
    // A kept remainder never exceeds twice the root, so it fits the field.
    step.rem  = ge ? SQ_RW'(trem - trial) : SQ_RW'(trem);
    step.root = {cur.root[SQ_QW-2:0], ge};
    step.val  = {cur.val[SQ_VW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nxt <= step;
    end
  end

endmodule

[src/mass_squared_pid_nsigma_core.sv]
// Channel   Direction  Handshake              Content
// trk       in         trk_valid / trk_stall  one track request (trk_t)
// res       out        res_valid / res_stall  one result per track (res_t)
// cfg       in         cfg_valid / cfg_ready  register index and write data
//
// One track is accepted every cycle unless a stall on res holds the pipeline.
// The latency is set by the rows of one-bit-per-cell dividers (48, 94 and
// 34 cells) and the 32-cell square-root row, plus ten arithmetic stages.
// Reset is synchronous; it clears the pipeline occupancy and loads the registers with their reset values.
// A stall on res while res_valid is high freezes the whole pipeline, and trk_stall follows it.
module mass_squared_pid_nsigma_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            trk_valid,
  output logic                            trk_stall,
  input  msnsig_pkg::trk_t                trk,
  output logic                            res_valid,
  input  logic                            res_stall,
  output msnsig_pkg::res_t                res,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [msnsig_pkg::IDX_W-1:0]    cfg_index,
  input  logic [msnsig_pkg::REG_W-1:0]    cfg_data
);
  import msnsig_pkg::*;

  typedef struct packed {
    logic [9:0]         tag;
    logic               ok;
    logic [29:0]        p2;
    logic [30:0]        wabs;
    logic               wpos;
    logic               wneg;
    logic signed [16:0] d;
  } sba_t;

  typedef struct packed {
    logic [9:0]         tag;
    logic               ok;
    logic [62:0]        alp;
    logic [60:0]        tof;
    logic               wpos;
    logic               wneg;
    logic signed [16:0] d;
  } sbb_t;

  typedef struct packed {
    logic [9:0]         tag;
    logic               ok;
    logic signed [16:0] d;
  } sbs_t;

  typedef struct packed {
    logic [9:0] tag;
    logic       ok;
    logic       dneg;
  } sbq_t;

  function automatic logic [62:0] sq_sat(input logic [47:0] x);
    logic [63:0] pr;
    pr = 64'(x[31:0]) * 64'(x[31:0]);
    if (x > 48'h0000_8000_0000) begin
      return SAT_CAP;
    end
    return pr[62:0];
  endfunction

  function automatic logic [62:0] add_cap(input logic [62:0] a, input logic [62:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, SAT_CAP}) begin
      return SAT_CAP;
    end
    return s[62:0];
  endfunction

  logic [REG_W-1:0] sigma_alpha, sigma_mult_scatt, sigma_tof_ps, sigma_emc_ps;
  logic [K_W-1:0]   k1_scale;
  logic             en;
  logic [LAT-1:0]   live;

  assign en        = !(res_valid && res_stall);
  assign trk_stall = !en;
  assign cfg_ready = 1'b1;
  assign res_valid = live[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma_alpha      <= RST_SIGMA_ALPHA;
      sigma_mult_scatt <= RST_SIGMA_MS;
      k1_scale         <= RST_K1_SCALE;
      sigma_tof_ps     <= RST_SIGMA_TOF;
      sigma_emc_ps     <= RST_SIGMA_EMC;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SIGMA_ALPHA: sigma_alpha      <= cfg_data;
        REG_SIGMA_MS:    sigma_mult_scatt <= cfg_data;
        REG_K1_SCALE:    k1_scale         <= cfg_data[K_W-1:0];
        REG_SIGMA_TOF:   sigma_tof_ps     <= cfg_data;
        REG_SIGMA_EMC:   sigma_emc_ps     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (en) begin
      live <= {live[LAT-2:0], trk_valid};
    end
  end

  // Front end: magnitudes, products and divisors.
  logic signed [16:0] mx, am_full, d_in;
  logic [15:0]        am;
  logic [K_W-1:0]     k_eff;
  logic [REG_W-1:0]   s_sel;

  always_comb begin
    mx      = 17'(trk.measured_mass_sq);
    am_full = mx[16] ? -mx : mx;
    am      = am_full[15:0];
    d_in    = mx - $signed({2'b00, trk.hypothesis_mass_sq});
    k_eff   = (k1_scale == '0) ? K_W'(1) : k1_scale;
    s_sel   = trk.mode ? sigma_emc_ps : sigma_tof_ps;
  end

  logic [9:0]         s0_tag;
  logic               s0_ok;
  logic [31:0]        s0_aam, s0_bam;
  logic [30:0]        s0_sp;
  logic [29:0]        s0_p2;
  logic [14:0]        s0_p;
  logic [17:0]        s0_t;
  logic [15:0]        s0_m;
  logic [20:0]        s0_dena;
  logic [16:0]        s0_denb;
  logic signed [16:0] s0_d;

  logic [9:0]         s1_tag;
  logic               s1_ok;
  logic [46:0]        s1_numa;
  logic [37:0]        s1_numb;
  logic [47:0]        s1_numy;
  logic [29:0]        s1_p2;
  logic [17:0]        s1_t;
  logic [20:0]        s1_dena;
  logic [16:0]        s1_denb;
  logic signed [16:0] s1_d;
  logic signed [31:0] s1_w;

  logic signed [31:0] w_next;

  always_comb begin
    w_next = $signed({2'b00, s0_p2}) + $signed({{8{s0_m[15]}}, s0_m, 8'd0});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_tag  <= trk.track_tag;
      s0_ok   <= (trk.momentum != '0) && (trk.flight_time_ps != '0);
      s0_aam  <= 32'(sigma_alpha) * 32'(am);
      s0_bam  <= 32'(sigma_mult_scatt) * 32'(am);
      s0_sp   <= 31'(s_sel) * 31'(trk.momentum);
      s0_p2   <= 30'(trk.momentum) * 30'(trk.momentum);
      s0_p    <= trk.momentum;
      s0_t    <= trk.flight_time_ps;
      s0_m    <= trk.measured_mass_sq;
      s0_dena <= 21'(k_eff) * 21'd2000;
      s0_denb <= 17'(k_eff) * 17'd125;
      s0_d    <= d_in;

      s1_tag  <= s0_tag;
      s1_ok   <= s0_ok;
      s1_numa <= 47'(s0_aam) * 47'(s0_p);
      s1_numb <= {s0_bam, 6'd0};
      s1_numy <= {s0_sp, 17'd0};
      s1_p2   <= s0_p2;
      s1_t    <= s0_t;
      s1_dena <= s0_dena;
      s1_denb <= s0_denb;
      s1_d    <= s0_d;
      s1_w    <= w_next;
    end
  end

  // First divider row: the three terms that feed the squares.
  div_t dva [STEPS_A+1];
  div_t dvb [STEPS_A+1];
  div_t dvy [STEPS_A+1];
  sba_t sba [STEPS_A+1];
  logic [31:0] w_neg;

  always_comb begin
    w_neg      = -s1_w;
    dva[0].rem = '0;
    dva[0].den = DIV_RW'(s1_dena);
    dva[0].num = {STEPS_A'(s1_numa), {(DIV_NW-STEPS_A){1'b0}}};
    dvb[0].rem = '0;
    dvb[0].den = DIV_RW'(s1_denb);
    dvb[0].num = {STEPS_A'(s1_numb), {(DIV_NW-STEPS_A){1'b0}}};
    dvy[0].rem = '0;
    dvy[0].den = DIV_RW'(s1_t);
    dvy[0].num = {STEPS_A'(s1_numy), {(DIV_NW-STEPS_A){1'b0}}};
    sba[0].tag  = s1_tag;
    sba[0].ok   = s1_ok;
    sba[0].p2   = s1_p2;
    sba[0].wabs = s1_w[31] ? w_neg[30:0] : s1_w[30:0];
    sba[0].wpos = !s1_w[31] && (s1_w != '0);
    sba[0].wneg = s1_w[31];
    sba[0].d    = s1_d;
  end

  genvar g;
  for (g = 0; g < STEPS_A; g++) begin : g_row_a
    msnsig_div_cell u_ua (.clk(clk), .en(en), .cur(dva[g]), .nxt(dva[g+1]));
    msnsig_div_cell u_ub (.clk(clk), .en(en), .cur(dvb[g]), .nxt(dvb[g+1]));
    msnsig_div_cell u_y  (.clk(clk), .en(en), .cur(dvy[g]), .nxt(dvy[g+1]));

    always_ff @(posedge clk) begin
      if (en) begin
        sba[g+1] <= sba[g];
      end
    end
  end

  // Squares, then the products with |w| split into two halves each.
  logic [62:0] s2_alp, s2_ub2, s2_y2;
  sba_t        s2_sb;
  logic [62:0] s3_alp, s3_bl, s3_yl;
  logic [61:0] s3_bh, s3_yh;
  sba_t        s3_sb;
  logic [62:0] s4_alp;
  logic [93:0] s4_prodb, s4_prody;
  sba_t        s4_sb;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_alp <= sq_sat(dva[STEPS_A].num[STEPS_A-1:0]);
      s2_ub2 <= sq_sat(dvb[STEPS_A].num[STEPS_A-1:0]);
      s2_y2  <= sq_sat(dvy[STEPS_A].num[STEPS_A-1:0]);
      s2_sb  <= sba[STEPS_A];

      s3_alp <= s2_alp;
      s3_bl  <= 63'(s2_ub2[31:0]) * 63'(s2_sb.wabs);
      s3_bh  <= 62'(s2_ub2[62:32]) * 62'(s2_sb.wabs);
      s3_yl  <= 63'(s2_y2[31:0]) * 63'(s2_sb.wabs);
      s3_yh  <= 62'(s2_y2[62:32]) * 62'(s2_sb.wabs);
      s3_sb  <= s2_sb;

      s4_alp   <= s3_alp;
      s4_prodb <= {s3_bh, 32'd0} + 94'(s3_bl);
      s4_prody <= {s3_yh, 32'd0} + 94'(s3_yl);
      s4_sb    <= s3_sb;
    end
  end

  // Second divider row: scattering term over p squared.
  div_t dvm [STEPS_B+1];
  sbb_t sbb [STEPS_B+1];

  always_comb begin
    dvm[0].rem  = '0;
    dvm[0].den  = DIV_RW'(s4_sb.p2);
    dvm[0].num  = {STEPS_B'(s4_prodb), {(DIV_NW-STEPS_B){1'b0}}};
    sbb[0].tag  = s4_sb.tag;
    sbb[0].ok   = s4_sb.ok;
    sbb[0].alp  = s4_alp;
    sbb[0].tof  = s4_prody[92:32];
    sbb[0].wpos = s4_sb.wpos;
    sbb[0].wneg = s4_sb.wneg;
    sbb[0].d    = s4_sb.d;
  end

  for (g = 0; g < STEPS_B; g++) begin : g_row_b
    msnsig_div_cell u_ms (.clk(clk), .en(en), .cur(dvm[g]), .nxt(dvm[g+1]));

    always_ff @(posedge clk) begin
      if (en) begin
        sbb[g+1] <= sbb[g];
      end
    end
  end

  // Variance assembly with saturation at the cap.
  logic [93:0] qb;
  logic [62:0] ms;
  logic [62:0] s5_side;
  sbb_t        s5_sb;
  logic [62:0] s6_pos, s6_neg;
  sbs_t        s6_sb;
  logic [62:0] s7_var;
  sbs_t        s7_sb;

  always_comb begin
    qb = dvm[STEPS_B].num[STEPS_B-1:0];
    ms = (qb > 94'(SAT_CAP)) ? SAT_CAP : qb[62:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_side <= add_cap(ms, 63'(sbb[STEPS_B].tof));
      s5_sb   <= sbb[STEPS_B];

      s6_pos    <= s5_sb.wpos ? add_cap(s5_sb.alp, s5_side) : s5_sb.alp;
      s6_neg    <= s5_sb.wneg ? s5_side : '0;
      s6_sb.tag <= s5_sb.tag;
      s6_sb.ok  <= s5_sb.ok;
      s6_sb.d   <= s5_sb.d;

      s7_var    <= s6_pos - s6_neg;
      s7_sb.tag <= s6_sb.tag;
      s7_sb.ok  <= s6_sb.ok && (s6_pos > s6_neg);
      s7_sb.d   <= s6_sb.d;
    end
  end

  // Square-root row.
  sq_t  sqr [STEPS_SQ+1];
  sbs_t sbs [STEPS_SQ+1];

  always_comb begin
    sqr[0].rem  = '0;
    sqr[0].root = '0;
    sqr[0].val  = SQ_VW'(s7_var);
    sbs[0]      = s7_sb;
  end

  for (g = 0; g < STEPS_SQ; g++) begin : g_row_sq
    msnsig_sqrt_cell u_sq (.clk(clk), .en(en), .cur(sqr[g]), .nxt(sqr[g+1]));

    always_ff @(posedge clk) begin
      if (en) begin
        sbs[g+1] <= sbs[g];
      end
    end
  end

  // Rounded quotient: (2*|d|*65536 + sigma) / (2*sigma).
  logic [31:0]        sig;
  logic signed [16:0] dabs_full;
  logic [33:0]        s8_numq;
  logic [32:0]        s8_den;
  sbq_t               s8_sb;

  always_comb begin
    sig       = sqr[STEPS_SQ].root;
    dabs_full = sbs[STEPS_SQ].d[16] ? -sbs[STEPS_SQ].d : sbs[STEPS_SQ].d;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_numq    <= {1'b0, dabs_full[15:0], 17'd0} + 34'(sig);
      s8_den     <= {sig, 1'b0};
      s8_sb.tag  <= sbs[STEPS_SQ].tag;
      s8_sb.ok   <= sbs[STEPS_SQ].ok && (sig != '0);
      s8_sb.dneg <= sbs[STEPS_SQ].d[16];
    end
  end

  div_t dvq [STEPS_Q+1];
  sbq_t sbq [STEPS_Q+1];

  always_comb begin
    dvq[0].rem = '0;
    dvq[0].den = DIV_RW'(s8_den);
    dvq[0].num = {STEPS_Q'(s8_numq), {(DIV_NW-STEPS_Q){1'b0}}};
    sbq[0]     = s8_sb;
  end

  for (g = 0; g < STEPS_Q; g++) begin : g_row_q
    msnsig_div_cell u_q (.clk(clk), .en(en), .cur(dvq[g]), .nxt(dvq[g+1]));

    always_ff @(posedge clk) begin
      if (en) begin
        sbq[g+1] <= sbq[g];
      end
    end
  end

  // Output stage: clamp magnitude, apply sign, saturate the positive side.
  logic [33:0] qq;
  logic [15:0] qmag, nbits;

  always_comb begin
    qq   = dvq[STEPS_Q].num[STEPS_Q-1:0];
    qmag = (qq > 34'd32768) ? 16'h8000 : qq[15:0];
    if (sbq[STEPS_Q].dneg) begin
      nbits = ~qmag + 16'd1;
    end else if (qmag > 16'h7FFF) begin
      nbits = 16'h7FFF;
    end else begin
      nbits = qmag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.track_tag_out <= sbq[STEPS_Q].tag;
      res.n_sigma       <= sbq[STEPS_Q].ok ? $signed(nbits) : 16'sd0;
      res.result_valid  <= sbq[STEPS_Q].ok;
    end
  end

endmodule

[bench/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import msnsig_pkg::*;

  localparam longint unsigned VAR_CAP = 64'd1 << 62;
  localparam int RANDOM_TRACKS = 1250;
  localparam int PHASES = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [IDX_W-1:0] IDX_UNUSED = 3'd7;

  typedef struct packed {
    trk_t track;
    logic typed;
    res_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic trk_valid = 1'b0;
  logic trk_stall;
  trk_t trk = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  longint unsigned alpha_q, mult_scatt_q, k1_q, tof_res_q, emc_res_q;
  res_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int random_sent = 0;

  dir_row_t directed_rows [12] = '{
    '{'{1'b0, 10'd0, 16'sd100, 18'd5000, 15'd0, 15'd80}, 1'b1, '{10'd0, 16'sd0, 1'b0}},
    '{'{1'b1, 10'd1023, -16'sd32768, 18'd0, 15'd32767, 15'd32767}, 1'b1,
      '{10'd1023, 16'sd0, 1'b0}},
    '{'{1'b1, 10'd1023, 16'sd32767, 18'd262143, 15'd32767, 15'd32767}, 1'b0, '0},
    '{'{1'b0, 10'd5, -16'sd32768, 18'd1, 15'd1, 15'd0}, 1'b0, '0},
    '{'{1'b0, 10'd6, -16'sd1, 18'd1000, 15'd16, 15'd0}, 1'b0, '0},
    '{'{1'b1, 10'd7, -16'sd4096, 18'd20000, 15'd1000, 15'd0}, 1'b0, '0},
    '{'{1'b0, 10'd8, 16'sd80, 18'd12000, 15'd2048, 15'd80}, 1'b0, '0},
    '{'{1'b1, 10'd9, 16'sd0, 18'd15000, 15'd4096, 15'd3998}, 1'b0, '0},
    '{'{1'b0, 10'd10, 16'sd16384, 18'd1, 15'd32767, 15'd0}, 1'b0, '0},
    '{'{1'b1, 10'd11, 16'sd32767, 18'd262143, 15'd1, 15'd0}, 1'b0, '0},
    '{'{1'b0, 10'd12, -16'sd100, 18'd262143, 15'd32767, 15'd32767}, 1'b0, '0},
    '{'{1'b1, 10'd13, 16'sd4096, 18'd10000, 15'd5000, 15'd4000}, 1'b0, '0}
  };

  mass_squared_pid_nsigma_core DUT (
    .clk(clk), .rst(rst),
    .trk_valid(trk_valid), .trk_stall(trk_stall), .trk(trk),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint unsigned cap_add(longint unsigned x, longint unsigned y);
    longint unsigned s;
    s = x + y;
    return (s > VAR_CAP) ? VAR_CAP : s;
  endfunction

  function automatic longint unsigned cap_mul(longint unsigned x, longint unsigned y);
    longint unsigned pr;
    if (x == 0 || y == 0) return 0;
    if (y > VAR_CAP / x) return VAR_CAP;
    pr = x * y;
    return (pr > VAR_CAP) ? VAR_CAP : pr;
  endfunction

  // Floor of v*m/d without losing the remainder's contribution.
  function automatic longint unsigned cap_scale(longint unsigned v, longint unsigned m,
                                                longint unsigned d);
    return cap_add(cap_mul(v / d, m), ((v % d) * m) / d);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bm;
    root = 0;
    bm = 64'd1 << 62;
    while (bm > v) bm = bm >> 2;
    while (bm != 0) begin
      if (v >= root + bm) begin
        v = v - (root + bm);
        root = (root >> 1) + bm;
      end else begin
        root = root >> 1;
      end
      bm = bm >> 2;
    end
    return root;
  endfunction

  function automatic res_t predict_deviation(trk_t t);
    res_t r;
    longint m, w, d, n;
    longint unsigned p, tt, k, s, am, p2, wabs, ua, ub, y, alp, side, pos, neg, sig, mag, q;
    r = '0;
    r.track_tag_out = t.track_tag;
    p = t.momentum;
    tt = t.flight_time_ps;
    if (p == 0 || tt == 0) return r;
    m = longint'(t.measured_mass_sq);
    k = (k1_q == 0) ? 1 : k1_q;
    s = t.mode ? emc_res_q : tof_res_q;
    am = (m < 0) ? -m : m;
    p2 = p * p;
    w = longint'(p2) + 256 * m;
    wabs = (w < 0) ? -w : w;
    ua = alpha_q * am * p / (2000 * k);
    alp = cap_mul(ua, ua);
    ub = mult_scatt_q * am * 64 / (125 * k);
    y = 2 * s * p * 65536 / tt;
    side = cap_add(cap_scale(cap_mul(ub, ub), wabs, p2),
                   cap_scale(cap_mul(y, y), wabs, 64'd1 << 32));
    pos = alp;
    neg = 0;
    if (w > 0) pos = cap_add(pos, side);
    else if (w < 0) neg = side;
    if (pos <= neg) return r;
    sig = int_sqrt(pos - neg);
    if (sig == 0) return r;
    d = m - longint'(t.hypothesis_mass_sq);
    mag = ((d < 0) ? -d : d) * 65536;
    q = (2 * mag + sig) / (2 * sig);
    if (q > 32768) q = 32768;
    n = (d < 0) ? -longint'(q) : longint'(q);
    if (n > 32767) n = 32767;
    r.n_sigma = n[15:0];
    r.result_valid = 1'b1;
    return r;
  endfunction

  function automatic trk_t random_track();
    trk_t t;
    int sel;
    t = '0;
    t.mode = 1'($urandom_range(1));
    t.track_tag = 10'($urandom);
    sel = $urandom_range(99);
    if (sel < 35) begin
      // Anything the fields can hold.
      t.measured_mass_sq = 16'($urandom);
      t.flight_time_ps = 18'($urandom);
      t.momentum = 15'($urandom);
      t.hypothesis_mass_sq = 15'($urandom);
    end else begin
      t.hypothesis_mass_sq = 15'($urandom_range(20000));
      t.measured_mass_sq = 16'(int'(t.hypothesis_mass_sq) + $urandom_range(8000) - 4000);
      t.momentum = 15'($urandom_range(8000, 100));
      t.flight_time_ps = 18'($urandom_range(40000, 5000));
    end
    if (sel >= 94 && sel < 97) t.momentum = '0;
    if (sel >= 97) t.flight_time_ps = '0;
    return t;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      REG_SIGMA_ALPHA: alpha_q = data;
      REG_SIGMA_MS:    mult_scatt_q = data;
      REG_K1_SCALE:    k1_q = data[K_W-1:0];
      REG_SIGMA_TOF:   tof_res_q = data;
      REG_SIGMA_EMC:   emc_res_q = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_track(trk_t t, logic typed, res_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      trk_valid = 1'b0;
      @(negedge clk);
    end
    trk_valid = 1'b1;
    trk = t;
    forever begin
      @(posedge clk);
      if (!trk_stall) break;
    end
    pending_results.push_back(typed ? want : predict_deviation(t));
    @(negedge clk);
  endtask

  task automatic drain();
    trk_valid = 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver side: random stalls, or one long hold-off when requested.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 400;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        res_stall = 1'b1;
        hold_left--;
      end else begin
        res_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, tag", res.track_tag_out, -1);
      end else begin
        want = pending_results.pop_front();
        if (res.track_tag_out !== want.track_tag_out)
          report_mismatch("track_tag_out", res.track_tag_out, want.track_tag_out);
        if (res.n_sigma !== want.n_sigma)
          report_mismatch("n_sigma", res.n_sigma, want.n_sigma);
        if (res.result_valid !== want.result_valid)
          report_mismatch("result_valid", res.result_valid, want.result_valid);
      end
    end
  end

  initial begin
    int per_phase;
    alpha_q = RST_SIGMA_ALPHA;
    mult_scatt_q = RST_SIGMA_MS;
    k1_q = RST_K1_SCALE;
    tof_res_q = RST_SIGMA_TOF;
    emc_res_q = RST_SIGMA_EMC;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_track(directed_rows[i].track, directed_rows[i].typed, directed_rows[i].want);

    per_phase = RANDOM_TRACKS / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: begin
            // Largest resolutions with the smallest divisor push the variance
            // into saturation.
            write_reg(REG_SIGMA_ALPHA, 16'hFFFF);
            write_reg(REG_SIGMA_MS, 16'hFFFF);
            write_reg(REG_K1_SCALE, 16'd1);
            write_reg(REG_SIGMA_TOF, 16'hFFFF);
            write_reg(REG_SIGMA_EMC, 16'hFFFF);
            write_reg(IDX_UNUSED, 16'h1234);
          end
          2: begin
            // A zero divisor counts as one; zero resolutions give no sigma.
            write_reg(REG_SIGMA_ALPHA, 16'd0);
            write_reg(REG_SIGMA_MS, 16'd0);
            write_reg(REG_K1_SCALE, 16'd0);
            write_reg(REG_SIGMA_TOF, 16'd0);
            write_reg(REG_SIGMA_EMC, 16'd340);
          end
          default: begin
            write_reg(REG_SIGMA_ALPHA, 16'($urandom_range(3000)));
            write_reg(REG_SIGMA_MS, 16'($urandom_range(3000)));
            write_reg(REG_K1_SCALE, 16'd1023);
            write_reg(REG_SIGMA_TOF, 16'($urandom_range(400, 20)));
            write_reg(REG_SIGMA_EMC, 16'($urandom_range(800, 100)));
          end
        endcase
      end
      for (int i = 0; i < per_phase; i++) begin
        case (random_sent * 3 / RANDOM_TRACKS)
          0: begin send_idle_pct = 38; recv_idle_pct = 55; end
          1: begin send_idle_pct = 55; recv_idle_pct = 38; end
          default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
        if (ph == 1 && i == 60) hold_req = 1'b1;
        if (ph == 1 && i == 200) drain();
        send_track(random_track(), 1'b0, '0);
        random_sent++;
      end
    end

    trk_valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (LAT + 20) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
